/* sv/hcrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrc_pkg
// Shared types, constants and match helpers of the HSV color region classifier.
// ----------------------------------------------------------------------------
package hcrc_pkg;

    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int PCT_W      = 7;
    localparam int DVD_W      = CNT_W + PCT_W;
    localparam int N_COLORS   = 5;
    localparam int IDX_W      = $clog2(N_COLORS);

    // color slots in the hit vector and the counter bank
    localparam int C_RED    = 0;
    localparam int C_BLUE   = 1;
    localparam int C_YELLOW = 2;
    localparam int C_BROWN  = 3;
    localparam int C_ORANGE = 4;

    localparam logic [7:0] BROWN_HUE      = 8'd10;
    localparam logic [7:0] BROWN_HUE_TOL  = 8'd20;
    localparam logic [7:0] BROWN_VAL      = 8'd76;
    localparam logic [7:0] BROWN_VAL_TOL  = 8'd40;
    localparam logic [7:0] ORANGE_HUE     = 8'd10;
    localparam logic [7:0] ORANGE_SAT     = 8'd191;
    localparam logic [7:0] ORANGE_SAT_TOL = 8'd50;
    localparam logic [8:0] HUE_WRAP       = 9'd180;
    localparam logic [8:0] VAL_WRAP       = 9'd255;

    typedef enum logic [2:0] {
        REG_SAT_MIN     = 3'd0,
        REG_RED_HUE     = 3'd1,
        REG_BLUE_HUE    = 3'd2,
        REG_YELLOW_HUE  = 3'd3,
        REG_HUE_TOL     = 3'd4,
        REG_RED_MIN_PCT = 3'd5,
        REG_YB_MIN_PCT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CL_RED    = 3'd0,
        CL_BLUE   = 3'd1,
        CL_YB     = 3'd2,
        CL_YELLOW = 3'd3,
        CL_NONE   = 3'd4
    } t_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    function automatic logic [10:0] abs11(input logic signed [10:0] x);
        return x < 0 ? 11'(-x) : 11'(x);
    endfunction

    // |a - ctr| < tol, also trying the difference shifted by +wrap and -wrap
    function automatic logic near_circ(input logic [7:0] a, input logic [7:0] ctr,
                                       input logic [7:0] tol, input logic [8:0] wrap);
        logic signed [10:0] d;
        logic signed [10:0] dp;
        logic signed [10:0] dm;
        d  = $signed({3'b000, a}) - $signed({3'b000, ctr});
        dp = d + $signed({2'b00, wrap});
        dm = d - $signed({2'b00, wrap});
        return (abs11(d) < {3'b000, tol}) || (abs11(dp) < {3'b000, tol}) ||
               (abs11(dm) < {3'b000, tol});
    endfunction

endpackage

/* sv/hsv_color_region_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_region_classifier
// Per-pixel HSV color rule match with region hit statistics and class code.
// ----------------------------------------------------------------------------
// Input words carry one HSV pixel (hue, sat, val) and a last flag closing
// the region. Every input word yields exactly one output word with the mask
// bit; on the last pixel that word also carries class_valid, the five hit
// percentages and the class code, and the region counters clear.
// Ordinary pixels: the word shows in the cycle after accept, one pixel per
// cycle as long as the output side takes each word.
// Last pixel: the five percentages run one after another through a single
// restoring divider, each after a load step, then the done state picks the
// class once the output register is free; the input is not ready meanwhile.
// A stalled output holds its word; the input stays not ready until the
// output register frees up.
// Reset (synchronous, active low) loads the register defaults, clears the
// counters and drops the output valid. Configuration writes take effect at
// once and are to be issued only while the block is idle (it does not check).
// ----------------------------------------------------------------------------
module hsv_color_region_classifier
    import hcrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    // pixel input
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_hue,
    input  logic [7:0]       i_sat,
    input  logic [7:0]       i_val,
    input  logic             i_last,
    // result output
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_mask,
    output logic             o_class_valid,
    output logic [2:0]       o_class_code,
    output logic [PCT_W-1:0] o_red_pct,
    output logic [PCT_W-1:0] o_blue_pct,
    output logic [PCT_W-1:0] o_yellow_pct,
    output logic [PCT_W-1:0] o_brown_pct,
    output logic [PCT_W-1:0] o_orange_pct
);

    // configuration registers
    logic [7:0] r_sat_min;
    logic [7:0] r_red_hue;
    logic [7:0] r_blue_hue;
    logic [7:0] r_yellow_hue;
    logic [6:0] r_hue_tol;
    logic [6:0] r_red_min_pct;
    logic [7:0] r_yb_min_pct;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] r_cnt [N_COLORS];
    logic [CNT_W-1:0] r_pix;
    logic [PCT_W-1:0] r_pct [N_COLORS];
    logic [IDX_W-1:0] r_idx;
    logic             r_mask_hold;

    logic             r_out_valid;
    logic             r_mask;
    logic             r_class_valid;
    logic [2:0]       r_class_code;
    logic [PCT_W-1:0] r_out_pct [N_COLORS];

    logic [N_COLORS-1:0] w_hit;
    logic                w_sat_ok;
    logic [7:0]          w_tol;
    logic                w_accept;
    logic                w_out_free;
    logic                w_div_start;
    logic                w_div_done;
    logic [PCT_W-1:0]    w_quot;
    logic                w_ld_cls;
    t_class              w_class;
    logic [7:0]          w_yb_sum;

    // ------------------------------------------------------------------
    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_min     <= 8'd100;
            r_red_hue     <= 8'd0;
            r_blue_hue    <= 8'd90;
            r_yellow_hue  <= 8'd32;
            r_hue_tol     <= 7'd17;
            r_red_min_pct <= 7'd8;
            r_yb_min_pct  <= 8'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SAT_MIN:     r_sat_min     <= i_cfg_data;
                REG_RED_HUE:     r_red_hue     <= i_cfg_data;
                REG_BLUE_HUE:    r_blue_hue    <= i_cfg_data;
                REG_YELLOW_HUE:  r_yellow_hue  <= i_cfg_data;
                REG_HUE_TOL:     r_hue_tol     <= i_cfg_data[6:0];
                REG_RED_MIN_PCT: r_red_min_pct <= i_cfg_data[6:0];
                REG_YB_MIN_PCT:  r_yb_min_pct  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-pixel rules
    assign w_tol    = {1'b0, r_hue_tol};
    assign w_sat_ok = i_sat > r_sat_min;

    always_comb begin
        w_hit[C_RED]    = w_sat_ok && near_circ(i_hue, r_red_hue, w_tol, HUE_WRAP);
        w_hit[C_BLUE]   = w_sat_ok && near_circ(i_hue, r_blue_hue, w_tol, HUE_WRAP);
        w_hit[C_YELLOW] = w_sat_ok && near_circ(i_hue, r_yellow_hue, w_tol, HUE_WRAP);
        w_hit[C_BROWN]  = near_circ(i_hue, BROWN_HUE, BROWN_HUE_TOL, HUE_WRAP) &&
                          near_circ(i_val, BROWN_VAL, BROWN_VAL_TOL, VAL_WRAP);
        // plain distance on saturation, no wraparound
        w_hit[C_ORANGE] = near_circ(i_sat, ORANGE_SAT, ORANGE_SAT_TOL, 9'd0) &&
                          near_circ(i_hue, ORANGE_HUE, w_tol, HUE_WRAP);
    end

    // ------------------------------------------------------------------
    // sequencer
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept && i_last) n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = (r_idx == IDX_W'(N_COLORS - 1)) ? ST_DONE : ST_START;
                end
            end
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_ld_cls    = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_ready  = w_out_free;
            ST_START: w_div_start = 1'b1;
            ST_DIV:   ;
            ST_DONE:  w_ld_cls    = w_out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // region counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
            for (int i = 0; i < N_COLORS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (w_ld_cls) begin
            r_pix <= '0;
            for (int i = 0; i < N_COLORS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (w_accept && (r_pix < CNT_W'(MAX_PIXELS))) begin
            r_pix <= r_pix + CNT_W'(1);
            for (int i = 0; i < N_COLORS; i++) begin
                r_cnt[i] <= r_cnt[i] + CNT_W'(w_hit[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_accept && i_last) begin
            r_idx <= '0;
        end else if (r_state == ST_DIV && w_div_done) begin
            r_pct[r_idx] <= w_quot;
            if (r_idx != IDX_W'(N_COLORS - 1)) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask_hold <= |w_hit;
        end
    end

    hcrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_count (r_cnt[r_idx]),
        .i_total (r_pix),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------------------
    // class pick, first rule that holds wins
    assign w_yb_sum = {1'b0, r_pct[C_YELLOW]} + {1'b0, r_pct[C_BROWN]};

    always_comb begin
        if (r_pct[C_RED] > r_red_min_pct && r_pct[C_RED] > r_pct[C_BLUE] &&
            r_pct[C_RED] > r_pct[C_YELLOW] && r_pct[C_RED] > r_pct[C_BROWN]) begin
            w_class = CL_RED;
        end else if (r_pct[C_BLUE] > r_pct[C_YELLOW] && r_pct[C_BLUE] > r_pct[C_BROWN] &&
                     r_pct[C_BLUE] > r_pct[C_ORANGE]) begin
            w_class = CL_BLUE;
        end else if (w_yb_sum > r_yb_min_pct) begin
            w_class = CL_YB;
        end else if (r_pct[C_YELLOW] > r_pct[C_ORANGE] &&
                     r_pct[C_YELLOW] > r_pct[C_BROWN]) begin
            w_class = CL_YELLOW;
        end else begin
            w_class = CL_NONE;
        end
    end

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && !i_last) || w_ld_cls) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_last) begin
            r_mask        <= |w_hit;
            r_class_valid <= 1'b0;
            r_class_code  <= 3'd0;
            for (int i = 0; i < N_COLORS; i++) begin
                r_out_pct[i] <= '0;
            end
        end else if (w_ld_cls) begin
            r_mask        <= r_mask_hold;
            r_class_valid <= 1'b1;
            r_class_code  <= w_class;
            for (int i = 0; i < N_COLORS; i++) begin
                r_out_pct[i] <= r_pct[i];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mask        = r_mask;
    assign o_class_valid = r_class_valid;
    assign o_class_code  = r_class_code;
    assign o_red_pct     = r_out_pct[C_RED];
    assign o_blue_pct    = r_out_pct[C_BLUE];
    assign o_yellow_pct  = r_out_pct[C_YELLOW];
    assign o_brown_pct   = r_out_pct[C_BROWN];
    assign o_orange_pct  = r_out_pct[C_ORANGE];

endmodule

/* sv/hcrc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrc_div
// Shared restoring divider: quotient of count*100 over total, one bit a cycle.
// ----------------------------------------------------------------------------
module hcrc_div
    import hcrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CNT_W-1:0] i_total,
    output logic             o_done,
    output logic [PCT_W-1:0] o_quot
);

    logic             r_busy;
    logic [2:0]       r_bit;
    logic [DVD_W-1:0] r_rem;
    logic [DVD_W-1:0] r_sub;
    logic [PCT_W-1:0] r_quot;
    logic [DVD_W-1:0] w_dvd;
    logic             w_ge;

    // count*100 = count*64 + count*32 + count*4
    assign w_dvd = (DVD_W'(i_count) << 6) + (DVD_W'(i_count) << 5) + (DVD_W'(i_count) << 2);
    assign w_ge  = r_rem >= r_sub;

    // quotient never exceeds 100 since count <= total, so PCT_W steps suffice
    assign o_done = r_busy && (r_bit == 3'd0);
    assign o_quot = {r_quot[PCT_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_dvd;
            r_sub  <= DVD_W'(i_total) << (PCT_W - 1);
            r_bit  <= 3'(PCT_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_sub;
            end
            r_sub  <= r_sub >> 1;
            r_quot <= {r_quot[PCT_W-2:0], w_ge};
            r_bit  <= r_bit - 3'd1;
        end
    end

endmodule

/* sv/hcrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcrc_checker
// Port-level checks of the HSV color region classifier, bound to the top.
// ----------------------------------------------------------------------------
module hcrc_checker
    import hcrc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_last,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_mask,
    input logic             o_class_valid,
    input logic [2:0]       o_class_code,
    input logic [PCT_W-1:0] o_red_pct,
    input logic [PCT_W-1:0] o_blue_pct,
    input logic [PCT_W-1:0] o_yellow_pct,
    input logic [PCT_W-1:0] o_brown_pct,
    input logic [PCT_W-1:0] o_orange_pct
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mask) &&
        $stable(o_class_valid) && $stable(o_class_code) && $stable(o_red_pct))
        else $error("output word changed while stalled");

    // an ordinary pixel shows up next cycle as a plain word
    a_pix_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_last |=> o_out_valid && !o_class_valid)
        else $error("ordinary pixel did not produce its word");

    // the region end keeps the input closed over the load and first divide step
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> !o_in_ready ##1 !o_in_ready)
        else $error("input reopened during class computation");

    // plain words carry no statistics
    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_class_valid |-> o_class_code == 3'd0 &&
        o_red_pct == '0 && o_blue_pct == '0 && o_yellow_pct == '0 &&
        o_brown_pct == '0 && o_orange_pct == '0)
        else $error("statistics on a non-final word");

    // percentages are bounded and the code is meaningful
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_class_valid |-> o_class_code <= CL_NONE &&
        o_red_pct <= 7'd100 && o_blue_pct <= 7'd100 && o_yellow_pct <= 7'd100 &&
        o_brown_pct <= 7'd100 && o_orange_pct <= 7'd100)
        else $error("class word out of range");

endmodule

bind hsv_color_region_classifier hcrc_checker u_hcrc_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HSV color region classifier.
// ----------------------------------------------------------------------------
// Pixel words go in over a valid/ready channel. The sender works in bursts
// with random gaps, and the receiver stalls in modes that change now and then.
// A scoreboard holds a shadow of the registers and the region counters. It
// works out the result word of each accepted pixel and checks the output
// words in order. Regions run under several register settings, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb_top;
    import hcrc_pkg::*;

    // color rule constants
    localparam int HUE_SPAN    = 180;
    localparam int VAL_SPAN    = 255;
    localparam int BRN_HUE     = 10;
    localparam int BRN_HUE_TOL = 20;
    localparam int BRN_VAL     = 76;
    localparam int BRN_VAL_TOL = 40;
    localparam int ORG_HUE     = 10;
    localparam int ORG_SAT     = 191;
    localparam int ORG_SAT_TOL = 50;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    localparam logic [2:0] REG_NONE = 3'd7;  // index with no register behind it

    typedef struct packed {
        logic             mask;
        logic             class_valid;
        logic [2:0]       class_code;
        logic [PCT_W-1:0] red_pct;
        logic [PCT_W-1:0] blue_pct;
        logic [PCT_W-1:0] yellow_pct;
        logic [PCT_W-1:0] brown_pct;
        logic [PCT_W-1:0] orange_pct;
    } pix_result_t;

    typedef enum int {PK_RED, PK_BLUE, PK_YELLOW, PK_BROWN, PK_ORANGE, PK_NOISE} pix_kind_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_TRICKLE} rx_mode_t;

    class region_scoreboard;
        int          sat_min     = 100;
        int          red_hue     = 0;
        int          blue_hue    = 90;
        int          yellow_hue  = 32;
        int          hue_tol     = 17;
        int          red_min_pct = 8;
        int          yb_min_pct  = 15;
        int unsigned hits [N_COLORS];
        int unsigned pixels;
        pix_result_t pending [$];
        int          errors;
        int          words;

        function new();
            foreach (hits[k]) hits[k] = 0;
            pixels = 0;
            errors = 0;
            words  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] d);
            case (idx)
                REG_SAT_MIN:     sat_min     = int'(d);
                REG_RED_HUE:     red_hue     = int'(d);
                REG_BLUE_HUE:    blue_hue    = int'(d);
                REG_YELLOW_HUE:  yellow_hue  = int'(d);
                REG_HUE_TOL:     hue_tol     = int'(d[6:0]);
                REG_RED_MIN_PCT: red_min_pct = int'(d[6:0]);
                REG_YB_MIN_PCT:  yb_min_pct  = int'(d);
                default: ;
            endcase
        endfunction

        static function int mag(int x);
            return (x < 0) ? -x : x;
        endfunction

        // distance test that also tries one span up and one span down
        static function bit near_wrap(int a, int ctr, int tol, int span);
            int d;
            d = a - ctr;
            return mag(d) < tol || mag(d + span) < tol || mag(d - span) < tol;
        endfunction

        function void note_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic l);
            logic [N_COLORS-1:0] hit;
            int                  pct [N_COLORS];
            pix_result_t         want;
            bit                  sat_hi;
            sat_hi = int'(s) > sat_min;
            hit[C_RED]    = sat_hi && near_wrap(int'(h), red_hue, hue_tol, HUE_SPAN);
            hit[C_BLUE]   = sat_hi && near_wrap(int'(h), blue_hue, hue_tol, HUE_SPAN);
            hit[C_YELLOW] = sat_hi && near_wrap(int'(h), yellow_hue, hue_tol, HUE_SPAN);
            hit[C_BROWN]  = near_wrap(int'(h), BRN_HUE, BRN_HUE_TOL, HUE_SPAN) &&
                            near_wrap(int'(v), BRN_VAL, BRN_VAL_TOL, VAL_SPAN);
            hit[C_ORANGE] = mag(int'(s) - ORG_SAT) < ORG_SAT_TOL &&
                            near_wrap(int'(h), ORG_HUE, hue_tol, HUE_SPAN);
            // past the cap neither the pixel nor its hits count
            if (pixels < MAX_PIXELS) begin
                pixels++;
                foreach (hits[k]) hits[k] += int'(hit[k]);
            end
            want      = '0;
            want.mask = |hit;
            if (l) begin
                foreach (pct[k])
                    pct[k] = (pixels == 0) ? 0 :
                             int'((longint'(hits[k]) * 100) / pixels) & 127;
                want.class_valid = 1'b1;
                if (pct[C_RED] > red_min_pct && pct[C_RED] > pct[C_BLUE] &&
                    pct[C_RED] > pct[C_YELLOW] && pct[C_RED] > pct[C_BROWN])
                    want.class_code = CL_RED;
                else if (pct[C_BLUE] > pct[C_YELLOW] && pct[C_BLUE] > pct[C_BROWN] &&
                         pct[C_BLUE] > pct[C_ORANGE])
                    want.class_code = CL_BLUE;
                else if (pct[C_YELLOW] + pct[C_BROWN] > yb_min_pct)
                    want.class_code = CL_YB;
                else if (pct[C_YELLOW] > pct[C_ORANGE] && pct[C_YELLOW] > pct[C_BROWN])
                    want.class_code = CL_YELLOW;
                else
                    want.class_code = CL_NONE;
                want.red_pct    = PCT_W'(pct[C_RED]);
                want.blue_pct   = PCT_W'(pct[C_BLUE]);
                want.yellow_pct = PCT_W'(pct[C_YELLOW]);
                want.brown_pct  = PCT_W'(pct[C_BROWN]);
                want.orange_pct = PCT_W'(pct[C_ORANGE]);
                foreach (hits[k]) hits[k] = 0;
                pixels = 0;
            end
            pending = {pending, want};
        endfunction

        function string show(pix_result_t r);
            return $sformatf("mask=%0b cv=%0b code=%0d pct r/b/y/br/o=%0d/%0d/%0d/%0d/%0d",
                             r.mask, r.class_valid, r.class_code, r.red_pct, r.blue_pct,
                             r.yellow_pct, r.brown_pct, r.orange_pct);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] ERROR %s", $realtime, msg);
        endfunction

        function void check_result(pix_result_t got);
            pix_result_t want;
            words++;
            if (pending.size() == 0) begin
                note_error($sformatf("word %0d with no pixel waiting: %s", words, show(got)));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                note_error($sformatf("word %0d: expected %s, got %s",
                                     words, show(want), show(got)));
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [2:0]       i_cfg_idx  = '0;
    logic [7:0]       i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_hue      = '0;
    logic [7:0]       i_sat      = '0;
    logic [7:0]       i_val      = '0;
    logic             i_last     = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_mask;
    logic             o_class_valid;
    logic [2:0]       o_class_code;
    logic [PCT_W-1:0] o_red_pct;
    logic [PCT_W-1:0] o_blue_pct;
    logic [PCT_W-1:0] o_yellow_pct;
    logic [PCT_W-1:0] o_brown_pct;
    logic [PCT_W-1:0] o_orange_pct;

    region_scoreboard sb = new();

    int       burst_left   = 0;
    bit       tx_full_rate = 1'b0;
    bit       rx_full_rate = 1'b0;
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_left      = 0;
    int       rx_tick      = 0;
    int       quiet        = 0;

    hsv_color_region_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_hue         (i_hue),
        .i_sat         (i_sat),
        .i_val         (i_val),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mask        (o_mask),
        .o_class_valid (o_class_valid),
        .o_class_code  (o_class_code),
        .o_red_pct     (o_red_pct),
        .o_blue_pct    (o_blue_pct),
        .o_yellow_pct  (o_yellow_pct),
        .o_brown_pct   (o_brown_pct),
        .o_orange_pct  (o_orange_pct)
    );

    always #2 i_clk = ~i_clk;

    // receiver: the ready pattern switches to a random mode when its run ends
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_TRICKLE));
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        rx_tick++;
        if (rx_full_rate) begin
            i_out_ready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:        i_out_ready <= 1'b1;
                RX_COIN:        i_out_ready <= 1'($urandom_range(0, 1));
                RX_EVERY_THIRD: i_out_ready <= (rx_tick % 3) != 0;
                default:        i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{mask: o_mask, class_valid: o_class_valid,
                              class_code: o_class_code, red_pct: o_red_pct,
                              blue_pct: o_blue_pct, yellow_pct: o_yellow_pct,
                              brown_pct: o_brown_pct, orange_pct: o_orange_pct});
    end

    // watchdog on cycles where neither channel moves a word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, quiet);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    task automatic push_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic l);
        i_in_valid <= 1'b1;
        i_hue      <= h;
        i_sat      <= s;
        i_val      <= v;
        i_last     <= l;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(h, s, v, l);
        @(negedge i_clk);
    endtask

    task automatic pace();
        if (tx_full_rate)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic send(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic l);
        push_pixel(h, s, v, l);
        pace();
    endtask

    // drain the block before touching registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [7:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        sb.write_reg(idx, d);
        @(negedge i_clk);
    endtask

    task automatic program_regs(logic [7:0] sat_min, logic [7:0] red_hue,
                                logic [7:0] blue_hue, logic [7:0] yellow_hue,
                                logic [7:0] hue_tol, logic [7:0] red_min_pct,
                                logic [7:0] yb_min_pct);
        put_reg(REG_SAT_MIN, sat_min);
        put_reg(REG_RED_HUE, red_hue);
        put_reg(REG_BLUE_HUE, blue_hue);
        put_reg(REG_YELLOW_HUE, yellow_hue);
        put_reg(REG_HUE_TOL, hue_tol);
        put_reg(REG_RED_MIN_PCT, red_min_pct);
        put_reg(REG_YB_MIN_PCT, yb_min_pct);
        put_reg(REG_NONE, 8'($urandom));  // must not land anywhere
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic pick_pixel(pix_kind_t kind, output logic [7:0] h, output logic [7:0] s,
                              output logic [7:0] v);
        int tol;
        int ctr;
        tol = sb.hue_tol + 3;
        h = 8'($urandom);
        s = 8'($urandom);
        v = 8'($urandom);
        case (kind)
            PK_RED, PK_BLUE, PK_YELLOW: begin
                ctr = (kind == PK_RED)  ? sb.red_hue :
                      (kind == PK_BLUE) ? sb.blue_hue : sb.yellow_hue;
                h = 8'((ctr + 2 * HUE_SPAN + $urandom_range(0, 2 * tol) - tol) % HUE_SPAN);
                if ($urandom_range(0, 4) != 0)
                    s = 8'($urandom_range(sb.sat_min, 255));
            end
            PK_BROWN: begin
                h = 8'((BRN_HUE + HUE_SPAN + $urandom_range(0, 44) - 22) % HUE_SPAN);
                v = 8'((BRN_VAL + 256 + $urandom_range(0, 90) - 45) % 256);
            end
            PK_ORANGE: begin
                h = 8'((ORG_HUE + HUE_SPAN + $urandom_range(0, 2 * tol) - tol) % HUE_SPAN);
                s = 8'(ORG_SAT + $urandom_range(0, 104) - 52);
            end
            default: ;
        endcase
    endtask

    // regions lean toward one color so every class code turns up
    task automatic run_regions(int n);
        int          done;
        int          len;
        pix_kind_t   bias;
        pix_kind_t   kind;
        logic [7:0]  h;
        logic [7:0]  s;
        logic [7:0]  v;
        done = 0;
        while (done < n) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
            bias = pix_kind_t'($urandom_range(PK_RED, PK_NOISE));
            for (int k = 1; k <= len; k++) begin
                kind = ($urandom_range(0, 9) < 6) ? bias :
                       pix_kind_t'($urandom_range(PK_RED, PK_NOISE));
                pick_pixel(kind, h, s, v);
                send(h, s, v, k == len);
            end
            done += len;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: rule edges, wrap, out-of-range hue
        send(8'd0,   8'd255, 8'd0,   1'b0);  // red
        send(8'd179, 8'd101, 8'd255, 1'b0);  // red across the hue wrap
        send(8'd16,  8'd100, 8'd36,  1'b0);  // sat equal to minimum, val at brown edge
        send(8'd17,  8'd101, 8'd0,   1'b0);  // hue at tolerance
        send(8'd90,  8'd200, 8'd0,   1'b0);  // blue
        send(8'd32,  8'd150, 8'd0,   1'b0);  // yellow
        send(8'd10,  8'd0,   8'd76,  1'b0);  // brown center
        send(8'd171, 8'd0,   8'd37,  1'b0);  // brown across the wrap
        send(8'd10,  8'd191, 8'd0,   1'b0);  // orange plus red
        send(8'd26,  8'd142, 8'd115, 1'b0);  // orange sat edge, yellow, brown
        send(8'd255, 8'd255, 8'd255, 1'b0);
        send(8'd180, 8'd241, 8'd116, 1'b1);
        send(8'd90,  8'd255, 8'd128, 1'b1);  // one-pixel region, blue
        send(8'd32,  8'd200, 8'd0,   1'b0);
        send(8'd10,  8'd0,   8'd80,  1'b0);
        send(8'd30,  8'd200, 8'd1,   1'b1);  // yellow plus brown
        send(8'd120, 8'd0,   8'd200, 1'b1);  // nothing matches
        send(8'd5,   8'd140, 8'd76,  1'b0);
        send(8'd128, 8'd127, 8'd127, 1'b1);

        run_regions(200);
        settle();
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0);
        run_regions(200);
        settle();
        program_regs(8'd255, 8'd179, 8'd179, 8'd179, 8'd90, 8'd100, 8'd200);
        run_regions(200);
        settle();
        // out-of-range hues, widest tolerance, top register bits set
        program_regs(8'd254, 8'd255, 8'd180, 8'd200, 8'hFF, 8'hFF, 8'hFF);
        tx_full_rate = 1'b1;
        run_regions(200);
        tx_full_rate = 1'b0;
        settle();
        // tolerance of zero: only brown can match
        program_regs(8'd60, 8'd150, 8'd5, 8'd175, 8'h80, 8'd30, 8'd40);
        rx_full_rate = 1'b1;
        run_regions(150);
        rx_full_rate = 1'b0;
        repeat (3) begin
            settle();
            program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 179)),
                         8'($urandom_range(0, 179)), 8'($urandom_range(0, 179)),
                         8'($urandom_range(1, 90)), 8'($urandom_range(0, 100)),
                         8'($urandom_range(0, 200)));
            run_regions(200);
        end

        settle();
        repeat (60) @(negedge i_clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
